### src/vlsdp_pkg.sv
// Shared types and constants for the vector line stepper and DAC packer.
package vlsdp_pkg;

    localparam int COORD_MAX_BITS = 12;
    localparam int DAC_BITS       = 12;
    localparam int SCALE_BITS     = 5;
    localparam int PROD_BITS      = COORD_MAX_BITS + SCALE_BITS;
    localparam int CFG_INDEX_BITS = 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 5'd1;
    localparam logic                  GAIN_RESET  = 1'b1;

    typedef enum logic [1:0] {
        OP_BEGIN   = 2'd0,
        OP_SEGMENT = 2'd1,
        OP_STEP    = 2'd2,
        OP_END     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_MOVE  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COORD_SCALE = 2'd0,
        CFG_GAIN_SELECT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_MAX_BITS-1:0] x;
        logic [COORD_MAX_BITS-1:0] y;
        logic [DAC_BITS-1:0]       z;
        cmd_t                      cmd;
        logic                      done;
    } point_t;

endpackage

### src/vlsdp_front.sv
// Front end: accepts operations, runs the Bresenham walk and queues points.
module vlsdp_front
    import vlsdp_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                operation,
    input  logic [COORD_MAX_BITS-1:0] x_coord,
    input  logic [COORD_MAX_BITS-1:0] y_coord,
    input  logic [DAC_BITS-1:0]       intensity,
    output logic                      push_valid,
    input  logic                      push_ready,
    output point_t                    push_point
);

    localparam int N = COORD_BITS;

    logic [N-1:0]        pen_x_reg, pen_x_next;
    logic [N-1:0]        pen_y_reg, pen_y_next;
    logic [N-1:0]        target_x_reg, target_x_next;
    logic [N-1:0]        target_y_reg, target_y_next;
    logic signed [N+2:0] step_error_reg, step_error_next;
    logic signed [N:0]   delta_x_reg, delta_x_next;
    logic signed [N:0]   delta_y_neg_reg, delta_y_neg_next;
    logic                step_x_neg_reg, step_x_neg_next;
    logic                step_y_neg_reg, step_y_neg_next;
    logic [DAC_BITS-1:0] intensity_reg, intensity_next;
    logic                seg_active_reg, seg_active_next;

    op_t                 op;
    logic [N-1:0]        xc, yc;
    logic                accept;
    logic                x_less, y_less;
    logic [N-1:0]        dx_mag, dy_mag;
    logic signed [N+3:0] e2;
    logic                move_x, move_y;
    logic                done;

    assign op       = op_t'(operation);
    assign xc       = x_coord[N-1:0];
    assign yc       = y_coord[N-1:0];
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign x_less   = pen_x_reg < xc;
    assign y_less   = pen_y_reg < yc;
    assign dx_mag   = x_less ? (xc - pen_x_reg) : (pen_x_reg - xc);
    assign dy_mag   = y_less ? (yc - pen_y_reg) : (pen_y_reg - yc);
    assign e2       = $signed({step_error_reg, 1'b0});
    assign move_x   = e2 > (N+4)'(delta_y_neg_reg);
    assign move_y   = e2 < (N+4)'(delta_x_reg);

    always_comb
    begin
        pen_x_next       = pen_x_reg;
        pen_y_next       = pen_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        step_error_next  = step_error_reg;
        delta_x_next     = delta_x_reg;
        delta_y_neg_next = delta_y_neg_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        intensity_next   = intensity_reg;
        seg_active_next  = seg_active_reg;
        done             = 1'b0;
        push_valid       = 1'b0;
        push_point.x     = '0;
        push_point.y     = '0;
        push_point.z     = intensity_reg;
        push_point.cmd   = CMD_MOVE;
        push_point.done  = 1'b0;
        case (op)
            OP_BEGIN:
            begin
                pen_x_next      = xc;
                pen_y_next      = yc;
                intensity_next  = intensity;
                seg_active_next = 1'b0;
                push_valid      = accept;
                push_point.z    = intensity;
                push_point.cmd  = CMD_START;
            end
            OP_SEGMENT:
            begin
                target_x_next    = xc;
                target_y_next    = yc;
                step_x_neg_next  = !x_less;
                step_y_neg_next  = !y_less;
                delta_x_next     = $signed({1'b0, dx_mag});
                delta_y_neg_next = -$signed({1'b0, dy_mag});
                step_error_next  = (N+3)'(delta_x_next) + (N+3)'(delta_y_neg_next);
                done             = (pen_x_reg == xc) && (pen_y_reg == yc);
                seg_active_next  = !done;
                push_valid       = accept;
                push_point.done  = done;
            end
            OP_STEP:
            begin
                if (seg_active_reg)
                begin
                    step_error_next = step_error_reg
                                    + (move_x ? (N+3)'(delta_y_neg_reg) : '0)
                                    + (move_y ? (N+3)'(delta_x_reg) : '0);
                    if (move_x)
                        pen_x_next = step_x_neg_reg ? pen_x_reg - 1'b1 : pen_x_reg + 1'b1;
                    if (move_y)
                        pen_y_next = step_y_neg_reg ? pen_y_reg - 1'b1 : pen_y_reg + 1'b1;
                    done            = (pen_x_next == target_x_reg)
                                   && (pen_y_next == target_y_reg);
                    seg_active_next = !done;
                    push_valid      = accept;
                    push_point.done = done;
                end
            end
            default:
            begin
                seg_active_next = 1'b0;
                push_valid      = accept;
                push_point.z    = '0;
                push_point.cmd  = CMD_STOP;
            end
        endcase
        push_point.x = COORD_MAX_BITS'(pen_x_next);
        push_point.y = COORD_MAX_BITS'(pen_y_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg       <= '0;
            pen_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            step_error_reg  <= '0;
            delta_x_reg     <= '0;
            delta_y_neg_reg <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            intensity_reg   <= '0;
            seg_active_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pen_x_reg       <= pen_x_next;
            pen_y_reg       <= pen_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            step_error_reg  <= step_error_next;
            delta_x_reg     <= delta_x_next;
            delta_y_neg_reg <= delta_y_neg_next;
            step_x_neg_reg  <= step_x_neg_next;
            step_y_neg_reg  <= step_y_neg_next;
            intensity_reg   <= intensity_next;
            seg_active_reg  <= seg_active_next;
        end
    end

    a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_STEP && !seg_active_reg) |-> !push_valid)
        else $error("step with no segment queued a word");

    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> accept)
        else $error("word queued without an accepted operation");

    a_done_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_point.done) |=> !seg_active_reg)
        else $error("segment still active after its target was reached");

endmodule

### src/vlsdp_queue.sv
// Short point queue between the stepper front end and the DAC packer.
module vlsdp_queue
    import vlsdp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  point_t push_point,
    output logic   pop_valid,
    input  logic   pop_ready,
    output point_t pop_point
);

    point_t                    mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic                      push, pop;

    assign push_ready = count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_point  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_point;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH))
            |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

### src/vlsdp_back.sv
// Back end: holds configuration, scales points and packs the DAC words.
module vlsdp_back
    import vlsdp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SCALE_BITS-1:0]     cfg_data,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  point_t                    pop_point,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [15:0]               x_word,
    output logic [15:0]               y_word,
    output logic [15:0]               z_word,
    output logic [1:0]                command,
    output logic                      segment_done
);

    logic [SCALE_BITS-1:0] coord_scale_reg;
    logic                  gain_select_reg;
    logic                  out_valid_reg;
    logic [15:0]           x_word_reg, y_word_reg, z_word_reg;
    logic [1:0]            command_reg;
    logic                  done_reg;
    logic [PROD_BITS-1:0]  x_prod, y_prod;
    logic [2:0]            common;
    logic                  pop;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign x_prod    = PROD_BITS'(pop_point.x) * PROD_BITS'(coord_scale_reg);
    assign y_prod    = PROD_BITS'(pop_point.y) * PROD_BITS'(coord_scale_reg);
    assign common    = {1'b0, gain_select_reg, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_scale_reg <= SCALE_RESET;
            gain_select_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_COORD_SCALE: coord_scale_reg <= cfg_data;
                CFG_GAIN_SELECT: gain_select_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop_ready)
            out_valid_reg <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_word_reg  <= {1'b0, common, x_prod[DAC_BITS-1:0]};
            y_word_reg  <= {1'b1, common, y_prod[DAC_BITS-1:0]};
            z_word_reg  <= {1'b0, common, ~pop_point.z};
            command_reg <= pop_point.cmd;
            done_reg    <= pop_point.done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x_word       = x_word_reg;
    assign y_word       = y_word_reg;
    assign z_word       = z_word_reg;
    assign command      = command_reg;
    assign segment_done = done_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("held word overwritten");

endmodule

### src/vector_line_stepper_dac_packer.sv
// Top level of the vector line stepper and DAC packer.
// An accepted operation's point passes through the point queue and then the output register.
// Throughput: one operation per cycle while the point queue has room; the four-entry
// point queue and the output register let the stepper keep running while the DAC side stalls.
// Reset (rst_n low, asynchronous): pen, segment and queue clear, coord_scale
// returns to 1 and gain_select to 1.
module vector_line_stepper_dac_packer
    import vlsdp_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SCALE_BITS-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                operation,
    input  logic [COORD_MAX_BITS-1:0] x_coord,
    input  logic [COORD_MAX_BITS-1:0] y_coord,
    input  logic [DAC_BITS-1:0]       intensity,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [15:0]               x_word,
    output logic [15:0]               y_word,
    output logic [15:0]               z_word,
    output logic [1:0]                command,
    output logic                      segment_done
);

    logic   push_valid, push_ready;
    point_t push_point;
    logic   pop_valid, pop_ready;
    point_t pop_point;

    vlsdp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .intensity  (intensity),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_point (push_point)
    );

    vlsdp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_point (push_point),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_point  (pop_point)
    );

    vlsdp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_point    (pop_point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .x_word       (x_word),
        .y_word       (y_word),
        .z_word       (z_word),
        .command      (command),
        .segment_done (segment_done)
    );

endmodule
